/* hw/rtl/hessian_outer_scatter_accumulate_unit_assert.svh */
// Assertion macros shared by the scatter-accumulate RTL.
// Expects signals clk and arst_n in the scope of each use.
`ifndef HESSIAN_OUTER_SCATTER_ACCUMULATE_UNIT_ASSERT_SVH
`define HESSIAN_OUTER_SCATTER_ACCUMULATE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define HOSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HOSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HOSA_ASSERT_IMP(label, ante, cons, msg)
`define HOSA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* hw/rtl/hosa_pkg.sv */
// Shared types, codes and constants of the Hessian scatter-accumulate unit.
// No dependencies; used by every module of the block.
package hosa_pkg;

	// default sizes
	localparam int MAX_PARAMS_DEF = 256;
	localparam int MAX_LOCAL_DEF  = 32;
	localparam int ACC_WIDTH_DEF  = 48;

	// fixed field widths
	localparam int IDX_W    = 8;
	localparam int STRIDE_W = 9;
	localparam int VAL_W    = 32;
	localparam int RD_W     = 48;
	localparam int PROD_W   = IDX_W + STRIDE_W + 1;

	localparam logic [STRIDE_W-1:0] STRIDE_RST = 9'd256;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_ACC   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_RANGE   = 2'd1,
		STS_FULL    = 2'd2,
		STS_SURPLUS = 2'd3
	} status_e;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_IDX,
		S_MRD,
		S_WB,
		S_RESP
	} state_e;

	typedef struct packed {
		cmd_e                     cmd;
		logic [IDX_W-1:0]         param_index;
		logic [IDX_W-1:0]         column_index;
		logic signed [VAL_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		status_e                  status;
		logic signed [RD_W-1:0]   read_data;
	} out_item_t;

	// index list controls and flags
	typedef struct packed {
		logic start;
		logic push;
		logic advance;
	} lst_ctl_t;

	typedef struct packed {
		logic full;
		logic no_pair;
	} lst_sts_t;

	// matrix store controls
	typedef struct packed {
		logic rd;
		logic wr;
	} mat_ctl_t;

	// index at or above the stride
	function automatic logic idx_bad(input logic [IDX_W-1:0] idx,
			input logic [STRIDE_W-1:0] stride);
		return STRIDE_W'(idx) >= stride;
	endfunction

endpackage

/* hw/rtl/hosa_index_list.sv */
// Local index list of one event plus the row-major pair walker.
// Depends on hosa_pkg; list entries sit in a small two-read-port memory.
`include "hessian_outer_scatter_accumulate_unit_assert.svh"
module hosa_index_list #(
	parameter int MAX_LOCAL = hosa_pkg::MAX_LOCAL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hosa_pkg::lst_ctl_t          ctl,
	input  logic [hosa_pkg::IDX_W-1:0]  push_index,
	output hosa_pkg::lst_sts_t          sts,
	output logic [hosa_pkg::IDX_W-1:0]  row_index,
	output logic [hosa_pkg::IDX_W-1:0]  col_index
);
	import hosa_pkg::*;

	localparam int CNT_W = $clog2(MAX_LOCAL + 1);
	localparam int LI_AW = (MAX_LOCAL > 1) ? $clog2(MAX_LOCAL) : 1;

	logic [IDX_W-1:0] idx_mem [MAX_LOCAL];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] col_inc;
	logic [IDX_W-1:0] row_rd_q;
	logic [IDX_W-1:0] col_rd_q;

	assign col_inc = col_q + CNT_W'(1);

	// flags for the sequencer
	assign sts.full    = count_q >= CNT_W'(MAX_LOCAL);
	assign sts.no_pair = row_q >= count_q;

	// counters: start clears, push grows the list, advance walks the pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (ctl.start) begin
			count_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.advance) begin
			if (col_inc >= count_q) begin
				col_q <= '0;
				row_q <= row_q + CNT_W'(1);
			end else begin
				col_q <= col_inc;
			end
		end
	end

	// list memory: one write, two registered reads of the current pair
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			idx_mem[count_q[LI_AW-1:0]] <= push_index;
		end
		if (ctl.advance) begin
			row_rd_q <= idx_mem[row_q[LI_AW-1:0]];
			col_rd_q <= idx_mem[col_q[LI_AW-1:0]];
		end
	end

	assign row_index = row_rd_q;
	assign col_index = col_rd_q;

	`HOSA_ASSERT_NXT(a_push_count, ctl.push, count_q == $past(count_q) + CNT_W'(1), "push lost")
	`HOSA_ASSERT_IMP(a_row_le_count, 1'b1, row_q <= count_q, "pair row beyond list")

endmodule

/* hw/rtl/hosa_matrix_store.sv */
// Dense accumulator matrix: single-port memory, saturating read-modify-write.
// Depends on hosa_pkg; runs a zeroing sweep over every entry after reset.
`include "hessian_outer_scatter_accumulate_unit_assert.svh"
module hosa_matrix_store #(
	parameter  int MAX_PARAMS = hosa_pkg::MAX_PARAMS_DEF,
	parameter  int ACC_WIDTH  = hosa_pkg::ACC_WIDTH_DEF,
	localparam int MAT_AW     = $clog2(MAX_PARAMS * MAX_PARAMS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hosa_pkg::mat_ctl_t                 ctl,
	input  logic [MAT_AW-1:0]                  addr,
	input  logic signed [hosa_pkg::VAL_W-1:0]  add_value,
	output logic signed [ACC_WIDTH-1:0]        rdata,
	output logic                               clearing
);
	import hosa_pkg::*;

	localparam int DEPTH = MAX_PARAMS * MAX_PARAMS;
	localparam int SUM_W = ACC_WIDTH + 1;

	logic signed [ACC_WIDTH-1:0] mem [DEPTH];
	logic signed [ACC_WIDTH-1:0] rdata_q;
	logic signed [SUM_W-1:0]     sum;
	logic signed [ACC_WIDTH-1:0] wr_data;
	logic [MAT_AW-1:0]           clr_addr_q;
	logic                        clearing_q;

	// saturating add of the fetched entry and the new value
	assign sum = SUM_W'(rdata_q) + SUM_W'(add_value);

	always_comb begin
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			wr_data = sum[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			wr_data = sum[ACC_WIDTH-1:0];
		end
	end

	// zeroing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == MAT_AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + MAT_AW'(1);
		end
	end

	// memory port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr) begin
			mem[addr] <= wr_data;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

	`HOSA_ASSERT_IMP(a_no_access_in_clear, ctl.wr || ctl.rd, !clearing_q, "access during sweep")
	`HOSA_ASSERT_NXT(a_sweep_once, !clearing_q, !clearing_q, "sweep restarted")

endmodule

/* hw/rtl/hessian_outer_scatter_accumulate_unit.sv */
// Top level of the Hessian scatter-accumulate unit: command sequencer,
// stride register, address multiplier and result register.
// Depends on hosa_pkg, hosa_index_list and hosa_matrix_store.
//
//  channel | role          | handshake                | payload
//  in      | command items | in_valid / in_stall      | in_data  (in_item_t)
//  out     | one result    | out_valid / out_stall    | out_data (out_item_t)
//  cfg     | matrix_stride | cfg_wr_en, no wait       | cfg_wr_data
//
// States per command after accept: start and push S_RESP; read S_MRD, S_WB,
// S_RESP; accumulate S_IDX, S_MRD, S_WB, S_RESP; an out-of-range read or a
// surplus value S_RESP only, a stale pair S_IDX, S_RESP. The registered matrix
// memory read and the index list read set the longer paths. After reset a
// zeroing sweep of all MAX_PARAMS*MAX_PARAMS entries (65536 by default) runs;
// in_stall stays high until the sweep ends and S_CLEAR is left; configuration writes are taken during it.
// A result waits in the output register while out_stall is high; the next
// command is taken only once the previous result has been loaded there.
`include "hessian_outer_scatter_accumulate_unit_assert.svh"
module hessian_outer_scatter_accumulate_unit #(
	parameter int MAX_PARAMS = hosa_pkg::MAX_PARAMS_DEF,
	parameter int MAX_LOCAL  = hosa_pkg::MAX_LOCAL_DEF,
	parameter int ACC_WIDTH  = hosa_pkg::ACC_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  hosa_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output hosa_pkg::out_item_t             out_data,
	input  logic                            cfg_wr_en,
	input  logic [hosa_pkg::STRIDE_W-1:0]   cfg_wr_data
);
	import hosa_pkg::*;

	localparam int MAT_AW = $clog2(MAX_PARAMS * MAX_PARAMS);

	state_e                      state_q;
	state_e                      state_d;
	logic [STRIDE_W-1:0]         stride_q;
	logic [STRIDE_W-1:0]         eff_stride;
	logic                        accept;
	logic                        slot_free;
	logic                        out_load;
	cmd_e                        cmd_q;
	logic signed [VAL_W-1:0]     value_q;
	status_e                     status_q;
	status_e                     accept_status;
	status_e                     idx_status;
	logic signed [RD_W-1:0]      res_data_q;
	logic [MAT_AW-1:0]           addr_q;
	logic [IDX_W-1:0]            mul_row;
	logic [IDX_W-1:0]            mul_col;
	logic [PROD_W-1:0]           addr_sum;
	logic                        out_valid_q;
	out_item_t                   out_data_q;
	logic                        read_bad;
	logic                        push_bad;
	lst_ctl_t                    lst_ctl;
	lst_sts_t                    lst_sts;
	logic [IDX_W-1:0]            lst_row;
	logic [IDX_W-1:0]            lst_col;
	mat_ctl_t                    mat_ctl;
	logic signed [ACC_WIDTH-1:0] mat_rdata;
	logic                        mat_clearing;

	// effective stride: zero acts as one, clamp to the matrix size
	always_comb begin
		if (stride_q == '0) begin
			eff_stride = STRIDE_W'(1);
		end else if (32'(stride_q) > 32'(MAX_PARAMS)) begin
			eff_stride = STRIDE_W'(MAX_PARAMS);
		end else begin
			eff_stride = stride_q;
		end
	end

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign read_bad  = idx_bad(in_data.param_index, eff_stride)
		|| idx_bad(in_data.column_index, eff_stride);
	assign push_bad  = idx_bad(in_data.param_index, eff_stride);

	// shared row * stride + col address multiplier
	assign addr_sum = PROD_W'(mul_row) * PROD_W'(eff_stride) + PROD_W'(mul_col);

	// status of a command at its transfer
	always_comb begin
		unique case (in_data.cmd)
			CMD_START: accept_status = STS_OK;
			CMD_PUSH:  accept_status = push_bad ? STS_RANGE
				: (lst_sts.full ? STS_FULL : STS_OK);
			CMD_ACC:   accept_status = lst_sts.no_pair ? STS_SURPLUS : STS_OK;
			CMD_READ:  accept_status = read_bad ? STS_RANGE : STS_OK;
			default:   accept_status = STS_OK;
		endcase
	end

	// stale list entries against the current stride
	assign idx_status = (idx_bad(lst_row, eff_stride) || idx_bad(lst_col, eff_stride))
		? STS_RANGE : STS_OK;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (!mat_clearing) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					unique case (in_data.cmd)
						CMD_START, CMD_PUSH: state_d = S_RESP;
						CMD_ACC:  state_d = lst_sts.no_pair ? S_RESP : S_IDX;
						CMD_READ: state_d = read_bad ? S_RESP : S_MRD;
						default:  state_d = S_RESP;
					endcase
				end
			end
			S_IDX:   state_d = (idx_status == STS_OK) ? S_MRD : S_RESP;
			S_MRD:   state_d = S_WB;
			S_WB:    state_d = S_RESP;
			S_RESP:  if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall        = (state_q != S_IDLE);
		out_load        = (state_q == S_RESP) && slot_free;
		lst_ctl.start   = accept && (in_data.cmd == CMD_START);
		lst_ctl.push    = accept && (in_data.cmd == CMD_PUSH) && !push_bad
			&& !lst_sts.full;
		lst_ctl.advance = accept && (in_data.cmd == CMD_ACC) && !lst_sts.no_pair;
		mat_ctl.rd      = (state_q == S_MRD);
		mat_ctl.wr      = (state_q == S_WB) && (cmd_q == CMD_ACC);
		if (state_q == S_IDX) begin
			mul_row = lst_row;
			mul_col = lst_col;
		end else begin
			mul_row = in_data.param_index;
			mul_col = in_data.column_index;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			stride_q    <= STRIDE_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				stride_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_data.cmd;
			value_q    <= in_data.value;
			status_q   <= accept_status;
			res_data_q <= '0;
			addr_q     <= MAT_AW'(addr_sum);
		end else if (state_q == S_IDX) begin
			status_q <= idx_status;
			addr_q   <= MAT_AW'(addr_sum);
		end else if ((state_q == S_WB) && (cmd_q == CMD_READ)) begin
			res_data_q <= RD_W'(mat_rdata);
		end
		if (out_load) begin
			out_data_q.status    <= status_q;
			out_data_q.read_data <= res_data_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	hosa_index_list #(
		.MAX_LOCAL (MAX_LOCAL)
	) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (lst_ctl),
		.push_index (in_data.param_index),
		.sts        (lst_sts),
		.row_index  (lst_row),
		.col_index  (lst_col)
	);

	hosa_matrix_store #(
		.MAX_PARAMS (MAX_PARAMS),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mat_ctl),
		.addr      (addr_q),
		.add_value (value_q),
		.rdata     (mat_rdata),
		.clearing  (mat_clearing)
	);

	`HOSA_ASSERT_NXT(a_busy_after_accept, accept, state_q != S_IDLE, "accepted item not held")
	`HOSA_ASSERT_IMP(a_load_from_resp, $rose(out_valid_q), $past(state_q) == S_RESP, "result from wrong state")

endmodule
